[hw/rtl/lpfr_pkg.sv]
// Package for the length-prefixed frame receiver.
// Holds the parse phase type, result kind codes, head constants and the result record.
// No dependencies.
package lpfr_pkg;

    // Frame head bytes
    localparam logic [7:0] HEAD_FIRST  = 8'h0d;
    localparam logic [7:0] HEAD_SECOND = 8'h0a;

    // Configuration register word index
    localparam logic REG_LEN_ORDER = 1'b0;

    // Position within a frame
    typedef enum logic [2:0] {
        PH_HEAD0 = 3'd0,
        PH_HEAD1 = 3'd1,
        PH_ADDR  = 3'd2,
        PH_CMD   = 3'd3,
        PH_LEN0  = 3'd4,
        PH_LEN1  = 3'd5,
        PH_DATA  = 3'd6,
        PH_SUM   = 3'd7
    } lpfr_phase_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_SUM_GOOD = 2'd1,
        KIND_SUM_BAD  = 2'd2
    } lpfr_kind_t;

    // One result record
    typedef struct packed {
        logic        head_mismatch;
        logic [15:0] data_length;
        logic [7:0]  frame_command;
        logic [7:0]  slave_address;
        logic [7:0]  payload_byte;
        lpfr_kind_t  kind;
    } lpfr_result_t;

endpackage

[hw/rtl/lpfr_parser.sv]
// Frame parser: phase sequencer, header holds, byte countdown and running checksum.
// Produces at most one result record per accepted byte. Depends on lpfr_pkg.
module lpfr_parser
    import lpfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         length_msb_first,
    input  logic         byte_valid,
    input  logic [7:0]   rx_byte,
    output logic         res_valid,
    output lpfr_result_t res
);

    lpfr_phase_t phase_reg,   phase_next;
    logic        head_bad_reg, head_bad_next;
    logic [7:0]  address_reg,  address_next;
    logic [7:0]  command_reg,  command_next;
    logic [15:0] length_reg,   length_next;
    logic [15:0] left_reg,     left_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [7:0]  sum_add;

    assign sum_add = sum_reg + rx_byte;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEAD0;
            head_bad_reg <= 1'b0;
            address_reg  <= 8'd0;
            command_reg  <= 8'd0;
            length_reg   <= 16'd0;
            left_reg     <= 16'd0;
            sum_reg      <= 8'd0;
        end
        else if (byte_valid)
        begin
            phase_reg    <= phase_next;
            head_bad_reg <= head_bad_next;
            address_reg  <= address_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            left_reg     <= left_next;
            sum_reg      <= sum_next;
        end
    end

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next    = phase_reg;
        head_bad_next = head_bad_reg;
        address_next  = address_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        left_next     = left_reg;
        sum_next      = sum_reg;
        res_valid     = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.slave_address = address_reg;
        res.frame_command = command_reg;
        res.data_length   = length_reg;
        res.head_mismatch = head_bad_reg;

        case (phase_reg)
            PH_HEAD0:
            begin
                head_bad_next = (rx_byte != HEAD_FIRST);
                phase_next    = PH_HEAD1;
            end
            PH_HEAD1:
            begin
                if (rx_byte != HEAD_SECOND)
                    head_bad_next = 1'b1;
                phase_next = PH_ADDR;
            end
            PH_ADDR:
            begin
                address_next = rx_byte;
                sum_next     = rx_byte;
                phase_next   = PH_CMD;
            end
            PH_CMD:
            begin
                command_next = rx_byte;
                sum_next     = sum_add;
                phase_next   = PH_LEN0;
            end
            PH_LEN0:
            begin
                if (length_msb_first)
                    length_next = {rx_byte, 8'd0};
                else
                    length_next = {8'd0, rx_byte};
                sum_next   = sum_add;
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                if (length_msb_first)
                    length_next = {length_reg[15:8], rx_byte};
                else
                    length_next = {rx_byte, length_reg[7:0]};
                left_next  = length_next;
                sum_next   = sum_add;
                phase_next = (length_next == 16'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                sum_next         = sum_add;
                res_valid        = byte_valid;
                res.payload_byte = rx_byte;
                left_next        = left_reg - 16'd1;
                if (left_reg == 16'd1)
                    phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                res_valid  = byte_valid;
                res.kind   = (sum_reg == rx_byte) ? KIND_SUM_GOOD : KIND_SUM_BAD;
                phase_next = PH_HEAD0;
            end
            default:
            begin
                phase_next = PH_HEAD0;
            end
        endcase
    end

endmodule

[hw/rtl/lpfr_out_buf.sv]
// Result register with a skid entry, so input can be taken while a result waits.
// Depends on lpfr_pkg.
module lpfr_out_buf
    import lpfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lpfr_result_t push_data,
    output logic         push_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output lpfr_result_t out_data
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    lpfr_result_t out_data_reg;
    lpfr_result_t skid_data_reg;
    logic         take;

    assign take       = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Occupancy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (push)
        begin
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            if (out_valid_reg)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

endmodule

[hw/rtl/length_prefixed_frame_receiver_top.sv]
// Length-prefixed frame receiver: takes one byte per cycle, parses head, address, command,
// 16-bit length, data and an 8-bit sum checksum. Uses one result register with a skid
// entry, so a byte is taken every cycle while the output side keeps up. Bytes go straight
// into the parser state; a result is registered in the result register or the skid entry.
// Data bytes come out as kind 0; the checksum byte gives a frame-end record (kind 1 good,
// kind 2 bad) with address, command, length and the head-mismatch flag. Header bytes give
// no output. Register 0 (byte address 0), bit 0: length byte order, 1 = high byte first.
// Depends on lpfr_pkg, lpfr_parser and lpfr_out_buf.
module length_prefixed_frame_receiver_top
    import lpfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_byte, [15:8] slave_address,
                                   // [23:16] frame_command, [39:24] data_length,
                                   // [40] head_mismatch, [47:41] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic         length_msb_first_reg;
    logic         byte_accept;
    logic         res_valid;
    lpfr_result_t res;
    lpfr_result_t out_res;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_msb_first_reg <= 1'b0;
        else if (psel && penable && pwrite && (paddr[2] == REG_LEN_ORDER))
            length_msb_first_reg <= pwdata[0];
    end

    assign prdata = (paddr[2] == REG_LEN_ORDER) ? {31'd0, length_msb_first_reg} : 32'd0;

    assign byte_accept = s_tvalid && s_tready;

    // Parser
    lpfr_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .length_msb_first (length_msb_first_reg),
        .byte_valid       (byte_accept),
        .rx_byte          (s_tdata),
        .res_valid        (res_valid),
        .res              (res)
    );

    // Output stage
    lpfr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {7'd0, out_res.head_mismatch, out_res.data_length,
                      out_res.frame_command, out_res.slave_address, out_res.payload_byte};
    assign m_tuser = out_res.kind;

endmodule
